// File: hw/rtl/calendar_timer_wheel_core_macros.svh
// ----------------------------------------------------------------------------
// Calendar timer wheel assertion macros
// Shared assertion forms, clocked by i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TIMER_WHEEL_CORE_MACROS_SVH
`define CALENDAR_TIMER_WHEEL_CORE_MACROS_SVH

// check a property on every clock edge outside reset
`define CTW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ctw assertion failed");

// check that a condition is followed by another in the next cycle
`define CTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ctw assertion failed");

`endif

// File: hw/rtl/ctw_pkg.sv
// ----------------------------------------------------------------------------
// Calendar timer wheel package
// Types, codes and helper functions shared by the timer wheel modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctw_pkg;

    localparam int MaxTimers = 32;
    localparam int IdxW      = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
    localparam int ResultCap = 32;
    localparam int KW        = $clog2(ResultCap + 1);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        LV_NONE = 3'd0,
        LV_SEC  = 3'd1,
        LV_MIN  = 3'd2,
        LV_HOUR = 3'd3,
        LV_WEEK = 3'd4,
        LV_MDAY = 3'd5
    } t_level;

    typedef struct packed {
        logic [5:0] mday;
        logic [3:0] wday;
        logic [5:0] hour;
        logic [6:0] min;
        logic [6:0] sec;
    } t_sched;

    typedef struct packed {
        logic [7:0] ident;
        t_sched     sched;
        logic [8:0] repeats;
        t_level     level;
    } t_entry;

    typedef struct packed {
        logic [4:0] mday;
        logic [2:0] wday;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } t_date;

    typedef struct packed {
        logic wk;
        logic md;
        logic hr;
        logic mn;
    } t_casc;

    typedef struct packed {
        t_entry entry;
        logic   fire;
        logic   keep;
    } t_upd;

    function automatic t_level top_level(input t_sched s);
        t_level lv;
        if (!s.mday[5]) begin
            lv = LV_MDAY;
        end else if (!s.wday[3]) begin
            lv = LV_WEEK;
        end else if (!s.hour[5]) begin
            lv = LV_HOUR;
        end else if (!s.min[6]) begin
            lv = LV_MIN;
        end else if (!s.sec[6]) begin
            lv = LV_SEC;
        end else begin
            lv = LV_NONE;
        end
        return lv;
    endfunction

    function automatic t_level add_level(input t_sched s, input t_date d);
        t_level lv;
        logic   hr_lt;
        logic   mn_lt;
        logic   sc_lt;
        hr_lt = $signed(s.hour) < $signed({1'b0, d.hour});
        mn_lt = $signed(s.min) < $signed({1'b0, d.min});
        sc_lt = $signed(s.sec) < $signed({1'b0, d.sec});
        if (!s.mday[5] && (s.mday[4:0] != d.mday || hr_lt)) begin
            lv = LV_MDAY;
        end else if (!s.wday[3] && (s.wday[2:0] != d.wday || hr_lt)) begin
            lv = LV_WEEK;
        end else if (!s.hour[5] && (s.hour[4:0] != d.hour || mn_lt)) begin
            lv = LV_HOUR;
        end else if (!s.min[6] && (s.min[5:0] != d.min || sc_lt)) begin
            lv = LV_MIN;
        end else if (!s.sec[6]) begin
            lv = LV_SEC;
        end else begin
            lv = LV_NONE;
        end
        return lv;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ctw_cmd_if.sv
// ----------------------------------------------------------------------------
// Calendar timer wheel command channel
// Valid/ready channel carrying tick, add and remove transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctw_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [7:0]        timer_id;
    logic signed [5:0] day_of_month;
    logic signed [3:0] day_of_week;
    logic signed [5:0] hour_field;
    logic signed [6:0] minute_field;
    logic signed [6:0] second_field;
    logic signed [8:0] repeat_count;

    modport source (
        output valid, cmd, timer_id, day_of_month, day_of_week, hour_field,
               minute_field, second_field, repeat_count,
        input  ready
    );
    modport sink (
        input  valid, cmd, timer_id, day_of_month, day_of_week, hour_field,
               minute_field, second_field, repeat_count,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/ctw_fire_if.sv
// ----------------------------------------------------------------------------
// Calendar timer wheel fire channel
// Valid/ready channel carrying one fired timer per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctw_fire_if;
    logic       valid;
    logic       ready;
    logic [7:0] fired_id;
    logic       last_fired;

    modport source (output valid, fired_id, last_fired, input ready);
    modport sink (input valid, fired_id, last_fired, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ctw_entry_update.sv
// ----------------------------------------------------------------------------
// Calendar timer wheel entry update
// Cascade, due check and repeat countdown of one timer entry on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_entry_update (
    input  wire  ctw_pkg::t_entry i_entry,
    input  wire                   i_valid,
    input  wire  ctw_pkg::t_date  i_date,
    input  wire  ctw_pkg::t_casc  i_casc,
    output ctw_pkg::t_upd         o_upd
);

    ctw_pkg::t_level lv;
    ctw_pkg::t_sched s;
    logic            due;
    logic [8:0]      rep;

    assign s = i_entry.sched;

    always_comb begin
        lv = i_entry.level;
        if (i_casc.wk && lv == ctw_pkg::LV_WEEK && !s.wday[3] && s.wday[2:0] == i_date.wday) begin
            lv = s.hour[5] ? ctw_pkg::LV_NONE : ctw_pkg::LV_HOUR;
        end
        if (i_casc.md && lv == ctw_pkg::LV_MDAY && !s.mday[5] && s.mday[4:0] == i_date.mday) begin
            lv = s.hour[5] ? ctw_pkg::LV_NONE : ctw_pkg::LV_HOUR;
        end
        if (i_casc.hr && lv == ctw_pkg::LV_HOUR && !s.hour[5] && s.hour[4:0] == i_date.hour) begin
            lv = s.min[6] ? ctw_pkg::LV_NONE : ctw_pkg::LV_MIN;
        end
        if (i_casc.mn && lv == ctw_pkg::LV_MIN && !s.min[6] && s.min[5:0] == i_date.min) begin
            lv = s.sec[6] ? ctw_pkg::LV_NONE : ctw_pkg::LV_SEC;
        end
        due = i_valid && lv == ctw_pkg::LV_SEC && !s.sec[6] && s.sec[5:0] == i_date.sec;

        rep        = i_entry.repeats;
        o_upd.fire = 1'b0;
        if (due) begin
            if (i_entry.repeats[8]) begin
                o_upd.fire = 1'b1;
            end else if (i_entry.repeats != 9'd0) begin
                o_upd.fire = 1'b1;
                rep        = i_entry.repeats - 9'd1;
            end
        end
        o_upd.keep          = !(due && rep == 9'd0);
        o_upd.entry         = i_entry;
        o_upd.entry.repeats = rep;
        o_upd.entry.level   = due ? ctw_pkg::top_level(s) : lv;
    end

endmodule

`default_nettype wire

// File: hw/rtl/calendar_timer_wheel_core.sv
// ----------------------------------------------------------------------------
// Calendar timer wheel core
// Cron-like hierarchical timer table held in one entry memory.
// ----------------------------------------------------------------------------
// Tick with a changed second: the walk reads one entry per cycle from the entry
//   memory, unless the fire output stalls it, and writes each valid entry back.
// Tick with an unchanged second or an unknown command: no walk, stays idle.
// Add: identifier scan, then one write (match or free slot). Remove: identifier scan.
// Reset clears the valid bits, the date and the output stage; no clearing pass.
`default_nettype none

module calendar_timer_wheel_core (
    input  wire       i_clk,
    input  wire       i_rst_n,
    ctw_cmd_if.sink   i_cmd_ch,
    ctw_fire_if.source o_fire_ch
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_WRITE = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    ctw_pkg::t_entry mem [ctw_pkg::MaxTimers];
    ctw_pkg::t_entry r_rd;

    logic [ctw_pkg::IdxW-1:0]      r_idx, n_idx, rd_addr;
    logic [ctw_pkg::MaxTimers-1:0] r_valid, n_valid;
    logic [1:0]                    r_op;
    logic [7:0]                    r_id;
    ctw_pkg::t_sched               r_sched;
    logic [8:0]                    r_rep;
    ctw_pkg::t_date                r_date, n_date;
    ctw_pkg::t_casc                r_casc, n_casc;
    logic                          r_hit, n_hit;
    logic [ctw_pkg::IdxW-1:0]      r_hit_idx, n_hit_idx;
    logic                          r_pend_vld, n_pend_vld;
    logic [7:0]                    r_pend_id, n_pend_id;
    logic [ctw_pkg::KW-1:0]        r_k, n_k;
    logic                          r_out_vld, n_out_vld;
    logic [7:0]                    r_out_id, n_out_id;
    logic                          r_out_last, n_out_last;

    logic                          accept, is_last, advance, out_free;
    logic                          we;
    logic [ctw_pkg::IdxW-1:0]      wa;
    ctw_pkg::t_entry               wd, add_ent;
    ctw_pkg::t_upd                 upd;
    logic                          free_any;
    logic [ctw_pkg::IdxW-1:0]      free_idx;
    logic                          v_cur;

    assign i_cmd_ch.ready      = (r_state == S_IDLE);
    assign accept              = i_cmd_ch.valid && i_cmd_ch.ready;
    assign o_fire_ch.valid     = r_out_vld;
    assign o_fire_ch.fired_id  = r_out_id;
    assign o_fire_ch.last_fired = r_out_last;
    assign out_free            = !r_out_vld || o_fire_ch.ready;
    assign is_last             = (r_idx == ctw_pkg::IdxW'(ctw_pkg::MaxTimers - 1));
    assign v_cur               = r_valid[r_idx];

    ctw_entry_update u_update (
        .i_entry (r_rd),
        .i_valid (v_cur),
        .i_date  (r_date),
        .i_casc  (r_casc),
        .o_upd   (upd)
    );

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ctw_pkg::MaxTimers - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = ctw_pkg::IdxW'(i);
            end
        end
    end

    always_comb begin
        add_ent.ident   = r_id;
        add_ent.sched   = r_sched;
        add_ent.repeats = r_rep;
        add_ent.level   = ctw_pkg::add_level(r_sched, r_date);
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_valid    = r_valid;
        n_date     = r_date;
        n_casc     = r_casc;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        n_k        = r_k;
        n_out_vld  = r_out_vld && !o_fire_ch.ready;
        n_out_id   = r_out_id;
        n_out_last = r_out_last;
        we         = 1'b0;
        wa         = r_idx;
        wd         = upd.entry;
        advance    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_hit      = 1'b0;
                    n_k        = '0;
                    n_pend_vld = 1'b0;
                    unique case (i_cmd_ch.cmd)
                        ctw_pkg::CMD_TICK: begin
                            n_date.sec  = i_cmd_ch.second_field[5:0];
                            n_date.min  = i_cmd_ch.minute_field[5:0];
                            n_date.hour = i_cmd_ch.hour_field[4:0];
                            n_date.wday = i_cmd_ch.day_of_week[2:0];
                            n_date.mday = i_cmd_ch.day_of_month[4:0];
                            n_casc.mn   = (r_date.min != n_date.min);
                            n_casc.hr   = n_casc.mn && (r_date.hour != n_date.hour);
                            n_casc.wk   = n_casc.hr && (r_date.wday != n_date.wday);
                            n_casc.md   = n_casc.hr && (r_date.mday != n_date.mday);
                            if (r_date.sec != n_date.sec) begin
                                n_state = S_WALK;
                            end
                        end
                        ctw_pkg::CMD_ADD, ctw_pkg::CMD_REMOVE: begin
                            n_state = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                unique case (r_op)
                    ctw_pkg::CMD_TICK: begin
                        if (!(v_cur && upd.fire && r_k < ctw_pkg::KW'(ctw_pkg::ResultCap)
                              && r_pend_vld && !out_free)) begin
                            advance = 1'b1;
                            if (v_cur) begin
                                we = 1'b1;
                                if (!upd.keep) begin
                                    n_valid[r_idx] = 1'b0;
                                end
                                if (upd.fire && r_k < ctw_pkg::KW'(ctw_pkg::ResultCap)) begin
                                    if (r_pend_vld) begin
                                        n_out_vld  = 1'b1;
                                        n_out_id   = r_pend_id;
                                        n_out_last = 1'b0;
                                    end
                                    n_pend_vld = 1'b1;
                                    n_pend_id  = r_rd.ident;
                                    n_k        = r_k + ctw_pkg::KW'(1);
                                end
                            end
                        end
                    end
                    ctw_pkg::CMD_ADD: begin
                        advance = 1'b1;
                        if (v_cur && r_rd.ident == r_id && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_idx;
                        end
                    end
                    default: begin
                        advance = 1'b1;
                        if (v_cur && r_rd.ident == r_id) begin
                            n_valid[r_idx] = 1'b0;
                        end
                    end
                endcase
                if (advance) begin
                    if (is_last) begin
                        n_idx = '0;
                        unique case (r_op)
                            ctw_pkg::CMD_TICK: n_state = S_FLUSH;
                            ctw_pkg::CMD_ADD:  n_state = S_WRITE;
                            default:           n_state = S_IDLE;
                        endcase
                    end else begin
                        n_idx = r_idx + ctw_pkg::IdxW'(1);
                    end
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
                wd      = add_ent;
                wa      = r_hit ? r_hit_idx : free_idx;
                if (r_hit || free_any) begin
                    we          = 1'b1;
                    n_valid[wa] = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_id   = r_pend_id;
                    n_out_last = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        rd_addr = n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_valid    <= '0;
            r_date     <= '0;
            r_casc     <= '0;
            r_hit      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_k        <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_valid    <= n_valid;
            r_date     <= n_date;
            r_casc     <= n_casc;
            r_hit      <= n_hit;
            r_pend_vld <= n_pend_vld;
            r_k        <= n_k;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_pend_id  <= n_pend_id;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
        if (accept) begin
            r_op            <= i_cmd_ch.cmd;
            r_id            <= i_cmd_ch.timer_id;
            r_sched.mday    <= i_cmd_ch.day_of_month;
            r_sched.wday    <= i_cmd_ch.day_of_week;
            r_sched.hour    <= i_cmd_ch.hour_field;
            r_sched.min     <= i_cmd_ch.minute_field;
            r_sched.sec     <= i_cmd_ch.second_field;
            r_rep           <= i_cmd_ch.repeat_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ctw_checker.sv
// ----------------------------------------------------------------------------
// Calendar timer wheel checker
// Port-level assertions for the timer wheel core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_timer_wheel_core_macros.svh"

module ctw_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire [1:0] i_in_cmd,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_fired_id,
    input wire       i_last_fired
);

    logic in_acc;
    logic tbl_op;
    logic bad_op;

    assign in_acc = i_in_valid && i_in_ready;
    assign tbl_op = (i_in_cmd == ctw_pkg::CMD_ADD) || (i_in_cmd == ctw_pkg::CMD_REMOVE);
    assign bad_op = !tbl_op && (i_in_cmd != ctw_pkg::CMD_TICK);

    // hold a stalled transaction
    `CTW_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_fired_id) && $stable(i_last_fired))
    `CTW_ASSERT_NEXT(a_tbl_busy, in_acc && tbl_op, !i_in_ready)
    `CTW_ASSERT_NEXT(a_tbl_no_fire, in_acc && tbl_op, !$rose(i_out_valid))
    `CTW_ASSERT_NEXT(a_bad_cmd_idle, in_acc && bad_op, i_in_ready)

endmodule

bind calendar_timer_wheel_core ctw_checker u_ctw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd_ch.valid),
    .i_in_ready   (i_cmd_ch.ready),
    .i_in_cmd     (i_cmd_ch.cmd),
    .i_out_valid  (o_fire_ch.valid),
    .i_out_ready  (o_fire_ch.ready),
    .i_fired_id   (o_fire_ch.fired_id),
    .i_last_fired (o_fire_ch.last_fired)
);

`default_nettype wire
